// ===== sv/ftm_pkg.sv =====
// Package for the fork-and-token mutual exclusion node.
// Holds the field widths, code names and the item structs that the channel
// interfaces and the core share. No dependencies.
package ftm_pkg;

  localparam int MaxNodes  = 15;
  localparam int NumSlots  = MaxNodes + 1;
  localparam int NodeIdxW  = $clog2(NumSlots);
  localparam int IdW       = 4;
  localparam int StampW    = 16;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 4;

  // Step modes of an input item
  localparam logic [1:0] ModeWant    = 2'd0;
  localparam logic [1:0] ModeRelease = 2'd1;
  localparam logic [1:0] ModeMsg     = 2'd2;

  // Kind of a received message
  localparam logic MsgRequest = 1'b0;
  localparam logic MsgReply   = 1'b1;

  // Kind of a result item
  localparam logic [1:0] SendNone    = 2'd0;
  localparam logic [1:0] SendRequest = 2'd1;
  localparam logic [1:0] SendFork    = 2'd2;
  localparam logic [1:0] SendGrant   = 2'd3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgOwnId     = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgNodeCount = 1'd1;

  typedef struct packed {
    logic [1:0]     mode;
    logic           msg_kind;
    logic [IdW-1:0] sender;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        send_kind;
    logic [IdW-1:0]    dest;
    logic [StampW-1:0] stamp;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] wdata;
  } cfg_wr_t;

endpackage

// ===== sv/ftm_if.sv =====
// Valid/ready channel interfaces of the mutual exclusion node.
// Payload types come from ftm_pkg.
interface ftm_in_if;
  import ftm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ftm_out_if;
  import ftm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ftm_cfg_if;
  import ftm_pkg::*;
  logic    valid;
  logic    ready;
  cfg_wr_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/fork_token_mutex_node_core.sv =====
// Core of one node of fork-and-token distributed mutual exclusion.
// Depends on ftm_pkg and the channel interfaces in ftm_if.sv.
//
// The node takes one item at a time on in_i and answers with one or more
// result items on out_o, the final one marked by last. A release item, a
// message that arrives while the node is not waiting, or an item that is
// ignored (bad sender, unused mode) goes straight to the finishing step. A
// want item, or a message that arrives while waiting, runs an evaluation
// pass: a sequencer walks the peer slots 1 to 15 once to hand over dirty
// tokened forks, checks the grant condition, then, unless it grants, walks
// the slots again to send request tokens. The single peer-scan index serves
// both walks; a stalled output holds the walks once a result is waiting.
// Results are staged in a one-deep holding register so that the last flag
// can be set on the final one; the output register lets the next item be
// accepted while the final result is still waiting to be taken.
// Configuration writes are always taken; a write of own_id reloads the
// per-peer fork and token bits to their initial pattern for the new id.
module fork_token_mutex_node_core
  import ftm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ftm_cfg_if.sink    cfg_i,
  ftm_in_if.sink     in_i,
  ftm_out_if.source  out_o
);

  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StGive   = 5'b00010,
    StCheck  = 5'b00100,
    StReq    = 5'b01000,
    StFinish = 5'b10000
  } state_e;

  localparam logic [NodeIdxW-1:0] LastSlot = NodeIdxW'(MaxNodes);

  state_e                state_q, state_d;
  logic [NodeIdxW-1:0]   k_q, k_d;
  logic [NumSlots-1:0]   held_q, held_d;
  logic [NumSlots-1:0]   clean_q, clean_d;
  logic [NumSlots-1:0]   token_q, token_d;
  logic                  waiting_q, waiting_d;
  logic [StampW-1:0]     clock_q, clock_d;
  logic [StampW-1:0]     req_stamp_q, req_stamp_d;
  logic [IdW-1:0]        own_id_q, own_id_d;
  logic [IdW-1:0]        node_count_q, node_count_d;
  logic                  pend_v_q, pend_v_d;
  out_item_t             pend_q, pend_d;
  logic                  out_v_q, out_v_d;
  out_item_t             out_q, out_d;

  logic [NumSlots-1:0]   peer;
  logic                  all_ok;
  logic                  out_free;
  logic                  emit_en;
  out_item_t             emit_item;
  logic [StampW-1:0]     clock_inc;
  logic [IdW-1:0]        snd;
  logic                  snd_ok;

  // Initial fork pattern: held for every lower id
  function automatic logic [NumSlots-1:0] init_held(input logic [IdW-1:0] id);
    logic [NumSlots-1:0] v;
    for (int j = 0; j < NumSlots; j++) begin
      v[j] = (j >= 1) && (IdW'(j) < id);
    end
    return v;
  endfunction

  // Initial token pattern: held for every higher id
  function automatic logic [NumSlots-1:0] init_token(input logic [IdW-1:0] id);
    logic [NumSlots-1:0] v;
    for (int j = 0; j < NumSlots; j++) begin
      v[j] = (IdW'(j) > id);
    end
    return v;
  endfunction

  // Active peers: ids 1..node_count other than our own
  always_comb begin
    for (int j = 0; j < NumSlots; j++) begin
      peer[j] = (j >= 1) && (IdW'(j) <= node_count_q) && (IdW'(j) != own_id_q);
    end
  end

  // Grant holds when every peer fork is held and either clean or untokened
  assign all_ok = &(~peer | (held_q & (clean_q | ~token_q)));

  assign out_free  = !out_v_q || out_o.ready;
  assign clock_inc = clock_q + StampW'(1);
  assign snd       = in_i.data.sender;
  assign snd_ok    = (snd != '0) && (snd != own_id_q) && (snd <= node_count_q);

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    held_d       = held_q;
    clean_d      = clean_q;
    token_d      = token_q;
    waiting_d    = waiting_q;
    clock_d      = clock_q;
    req_stamp_d  = req_stamp_q;
    own_id_d     = own_id_q;
    node_count_d = node_count_q;
    pend_v_d     = pend_v_q;
    pend_d       = pend_q;
    out_v_d      = out_v_q;
    out_d        = out_q;
    emit_en      = 1'b0;
    emit_item    = '0;

    // Drop the output item once taken
    if (out_v_q && out_o.ready) begin
      out_v_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_i.valid) begin
          k_d     = NodeIdxW'(1);
          state_d = StFinish;
          case (in_i.data.mode)
            ModeWant: begin
              clock_d     = clock_inc;
              req_stamp_d = clock_inc;
              waiting_d   = 1'b1;
              state_d     = StGive;
            end
            ModeRelease: begin
              clean_d = '0;
            end
            ModeMsg: begin
              if (snd_ok) begin
                if (in_i.data.msg_kind == MsgRequest) begin
                  token_d[snd] = 1'b1;
                  if (!clean_q[snd] && waiting_q) begin
                    held_d[snd] = 1'b0;
                    clock_d     = clock_inc;
                    emit_en     = 1'b1;
                    emit_item   = '{send_kind: SendFork, dest: snd,
                                    stamp: clock_inc, last: 1'b0};
                  end
                end else begin
                  held_d[snd]  = 1'b1;
                  clean_d[snd] = 1'b1;
                end
                if (waiting_q) begin
                  state_d = StGive;
                end
              end
            end
            default: ;
          endcase
        end
      end

      StGive: begin
        // Hand over each dirty fork whose token we hold
        if (out_free) begin
          if (peer[k_q] && !clean_q[k_q] && token_q[k_q] && held_q[k_q]) begin
            held_d[k_q] = 1'b0;
            clock_d     = clock_inc;
            emit_en     = 1'b1;
            emit_item   = '{send_kind: SendFork, dest: IdW'(k_q),
                            stamp: clock_inc, last: 1'b0};
          end
          if (k_q == LastSlot) begin
            state_d = StCheck;
          end else begin
            k_d = k_q + NodeIdxW'(1);
          end
        end
      end

      StCheck: begin
        if (out_free) begin
          k_d = NodeIdxW'(1);
          if (all_ok) begin
            waiting_d = 1'b0;
            emit_en   = 1'b1;
            emit_item = '{send_kind: SendGrant, dest: '0,
                          stamp: clock_q, last: 1'b0};
            state_d   = StFinish;
          end else begin
            state_d = StReq;
          end
        end
      end

      StReq: begin
        // Send the request token for every missing fork
        if (out_free) begin
          if (peer[k_q] && token_q[k_q] && !held_q[k_q]) begin
            token_d[k_q] = 1'b0;
            emit_en      = 1'b1;
            emit_item    = '{send_kind: SendRequest, dest: IdW'(k_q),
                             stamp: req_stamp_q, last: 1'b0};
          end
          if (k_q == LastSlot) begin
            state_d = StFinish;
          end else begin
            k_d = k_q + NodeIdxW'(1);
          end
        end
      end

      StFinish: begin
        // Flush the held result as the final one, or an empty result
        if (out_free) begin
          out_v_d    = 1'b1;
          out_d      = pend_v_q ? pend_q : '0;
          out_d.last = 1'b1;
          pend_v_d   = 1'b0;
          state_d    = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase

    // Advance the holding stage: the older result moves to the output
    if (emit_en) begin
      if (pend_v_q) begin
        out_v_d    = 1'b1;
        out_d      = pend_q;
        out_d.last = 1'b0;
      end
      pend_d   = emit_item;
      pend_v_d = 1'b1;
    end

    if (cfg_i.valid) begin
      unique case (cfg_i.data.idx)
        CfgOwnId: begin
          own_id_d = cfg_i.data.wdata;
          held_d   = init_held(cfg_i.data.wdata);
          clean_d  = '0;
          token_d  = init_token(cfg_i.data.wdata);
        end
        CfgNodeCount: begin
          node_count_d = cfg_i.data.wdata;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      k_q          <= NodeIdxW'(1);
      held_q       <= init_held(IdW'(1));
      clean_q      <= '0;
      token_q      <= init_token(IdW'(1));
      waiting_q    <= 1'b0;
      clock_q      <= '0;
      req_stamp_q  <= '0;
      own_id_q     <= IdW'(1);
      node_count_q <= IdW'(2);
      pend_v_q     <= 1'b0;
      out_v_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      k_q          <= k_d;
      held_q       <= held_d;
      clean_q      <= clean_d;
      token_q      <= token_d;
      waiting_q    <= waiting_d;
      clock_q      <= clock_d;
      req_stamp_q  <= req_stamp_d;
      own_id_q     <= own_id_d;
      node_count_q <= node_count_d;
      pend_v_q     <= pend_v_d;
      out_v_q      <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign in_i.ready  = (state_q == StIdle);
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for fork_token_mutex_node_core: directed and random
// want, release and message items, checked against an in-bench node predictor.
// Depends on ftm_pkg and the channel interfaces in ftm_if.sv.
module testbench;
  import ftm_pkg::*;

  // Mode 3 has no meaning; the node must ignore it
  localparam logic [1:0] ModeUnused = 2'd3;
  // Margin after the last result before touching the registers
  localparam int SettleCycles = 40;
  // Cycles without any handshake before the run is declared hung
  localparam int WatchdogLimit = 2000;
  localparam int MaxSends = 32;

  logic clk = 1'b0;
  logic rst_n;

  ftm_cfg_if cfg_if ();
  ftm_in_if  in_if ();
  ftm_out_if out_if ();

  fork_token_mutex_node_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Stimulus stores and bookkeeping
  // ---------------------------------------------------------------------------
  in_item_t  queued_items[$];     // items waiting to be driven
  cfg_wr_t   pending_writes[$];   // register writes waiting to be driven
  out_item_t predicted_sends[$];  // results the node still owes, oldest first
  out_item_t step_sends[$];       // results of the item being predicted

  logic no_gaps;                  // hold both sides free of idling
  int   item_gap;
  int   stall_left;
  int   stall_draw;
  int   idle_cycles;

  int fail_count;
  int items_seen;
  int sends_checked;
  int grants_seen;
  int forks_seen;
  int requests_seen;
  int settings_used;

  // ---------------------------------------------------------------------------
  // Node predictor: its own copy of the per-peer bits, clock and registers.
  // Bit k of each vector belongs to peer id k; bit 0 is never a peer.
  // ---------------------------------------------------------------------------
  logic [15:0] nd_fork_held;
  logic [15:0] nd_fork_clean;
  logic [15:0] nd_token_held;
  logic        nd_waiting;
  logic [15:0] nd_clock;
  logic [15:0] nd_req_stamp;
  logic [3:0]  nd_own;
  logic [3:0]  nd_count;

  // Forks start with the lower id, tokens with the higher id, all forks dirty
  task automatic reload_links();
    int j;
    for (j = 0; j <= MaxNodes; j++) begin
      nd_fork_held[j]  = (j >= 1 && j < nd_own);
      nd_fork_clean[j] = 1'b0;
      nd_token_held[j] = (j > nd_own);
    end
  endtask

  task automatic add_send(logic [1:0] kind, logic [3:0] dest, logic [15:0] stamp);
    out_item_t s;
    s.send_kind = kind;
    s.dest      = dest;
    s.stamp     = stamp;
    s.last      = 1'b0;
    // Anything past the result limit is dropped, the state still moves
    if (step_sends.size() < MaxSends) step_sends.push_back(s);
  endtask

  // One evaluation pass: hand over dirty tokened forks, then grant or ask
  task automatic predict_pass();
    int k;
    int lim;
    int peers;
    int ok;
    lim   = (nd_count > MaxNodes) ? MaxNodes : nd_count;
    peers = 0;
    ok    = 0;
    for (k = 1; k <= lim; k++) begin
      if (k != nd_own && !nd_fork_clean[k] && nd_token_held[k] && nd_fork_held[k]) begin
        nd_fork_held[k] = 1'b0;
        nd_clock = nd_clock + 16'd1;
        add_send(SendFork, 4'(k), nd_clock);
      end
    end
    for (k = 1; k <= lim; k++) begin
      if (k != nd_own) begin
        peers++;
        if (nd_fork_held[k] && (nd_fork_clean[k] || !nd_token_held[k])) ok++;
      end
    end
    if (ok == peers) begin
      nd_waiting = 1'b0;
      add_send(SendGrant, 4'd0, nd_clock);
    end else begin
      for (k = 1; k <= lim; k++) begin
        if (k != nd_own && nd_token_held[k] && !nd_fork_held[k]) begin
          nd_token_held[k] = 1'b0;
          add_send(SendRequest, 4'(k), nd_req_stamp);
        end
      end
    end
  endtask

  // Work out every result one accepted item causes and queue them
  task automatic predict_node_step(in_item_t it);
    int k;
    int lim;
    out_item_t tail;
    step_sends.delete();
    lim = (nd_count > MaxNodes) ? MaxNodes : nd_count;
    case (it.mode)
      ModeWant: begin
        nd_clock     = nd_clock + 16'd1;
        nd_req_stamp = nd_clock;
        nd_waiting   = 1'b1;
        predict_pass();
      end
      ModeRelease: begin
        for (k = 1; k <= MaxNodes; k++) if (k != nd_own) nd_fork_clean[k] = 1'b0;
      end
      ModeMsg: begin
        // Bad senders (zero, ourselves, outside the peer range) change nothing
        if (it.sender != 0 && it.sender != nd_own && it.sender <= lim) begin
          if (it.msg_kind == MsgRequest) begin
            nd_token_held[it.sender] = 1'b1;
            if (!nd_fork_clean[it.sender] && nd_waiting) begin
              nd_fork_held[it.sender] = 1'b0;
              nd_clock = nd_clock + 16'd1;
              add_send(SendFork, it.sender, nd_clock);
            end
          end else begin
            nd_fork_held[it.sender]  = 1'b1;
            nd_fork_clean[it.sender] = 1'b1;
          end
          if (nd_waiting) predict_pass();
        end
      end
      default: ;
    endcase
    // A step that sends nothing still answers with one empty result
    if (step_sends.size() == 0) add_send(SendNone, 4'd0, 16'd0);
    tail = step_sends.pop_back();
    tail.last = 1'b1;
    step_sends.push_back(tail);
    while (step_sends.size() != 0) predicted_sends.push_back(step_sends.pop_front());
    items_seen++;
  endtask

  task automatic apply_write(cfg_wr_t w);
    if (w.idx == CfgOwnId) begin
      nd_own = w.wdata;
      reload_links();
    end else if (w.idx == CfgNodeCount) begin
      nd_count = w.wdata;
    end
  endtask

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic check_send(out_item_t got);
    out_item_t due;
    if (predicted_sends.size() == 0) begin
      $error("unpredicted result: send_kind %0d dest %0d stamp %0d last %0d",
             got.send_kind, got.dest, got.stamp, got.last);
      fail_count++;
    end else begin
      due = predicted_sends.pop_front();
      check_field("send_kind", 32'(due.send_kind), 32'(got.send_kind));
      check_field("dest", 32'(due.dest), 32'(got.dest));
      check_field("stamp", 32'(due.stamp), 32'(got.stamp));
      check_field("last", 32'(due.last), 32'(got.last));
    end
    sends_checked++;
    if (got.send_kind == SendGrant) grants_seen++;
    if (got.send_kind == SendFork) forks_seen++;
    if (got.send_kind == SendRequest) requests_seen++;
  endtask

  // Mostly no gap or a short one, now and then a long one
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Item driver: launch the next queued item once the previous one is taken,
  // with a random gap after each launch unless no_gaps is set.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
      item_gap    <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (item_gap != 0) begin
        in_if.valid <= 1'b0;
        item_gap    <= item_gap - 1;
      end else if (queued_items.size() != 0) begin
        in_if.valid <= 1'b1;
        in_if.data  <= queued_items.pop_front();
        item_gap    <= no_gaps ? 0 : draw_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Register write driver: writes go out back to back, only while idle
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      cfg_if.valid <= 1'b0;
      cfg_if.data  <= '0;
    end else if (!cfg_if.valid || cfg_if.ready) begin
      if (pending_writes.size() != 0) begin
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= pending_writes.pop_front();
      end else begin
        cfg_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check taken results first, then fold in register writes and new
  // items, so the order within an edge never matters. Also drive the result
  // side's ready with random stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
      nd_own       = 4'd1;
      nd_count     = 4'd2;
      nd_waiting   = 1'b0;
      nd_clock     = 16'd0;
      nd_req_stamp = 16'd0;
      reload_links();
    end else begin
      if (out_if.valid && out_if.ready) check_send(out_if.data);
      if (cfg_if.valid && cfg_if.ready) apply_write(cfg_if.data);
      if (in_if.valid && in_if.ready) predict_node_step(in_if.data);
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (no_gaps) begin
        out_if.ready <= 1'b1;
      end else begin
        stall_draw = draw_gap();
        out_if.ready <= (stall_draw == 0);
        stall_left   <= (stall_draw == 0) ? 0 : stall_draw - 1;
      end
    end
  end

  // Watchdog: end the run if no handshake of any kind happens for too long
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_item(logic [1:0] mode, logic kind, logic [3:0] sender);
    in_item_t it;
    it.mode     = mode;
    it.msg_kind = kind;
    it.sender   = sender;
    queued_items.push_back(it);
  endtask

  // Any id in the peer range other than our own
  function automatic logic [3:0] pick_peer(int own, int count);
    int s;
    do s = $urandom_range(1, count); while (s == own);
    return 4'(s);
  endfunction

  // Wait until every item is taken and every result has come, then settle
  task automatic drain();
    do @(negedge clk);
    while (queued_items.size() != 0 || in_if.valid || predicted_sends.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Move the node to a new id and size; only ever done with the node idle
  task automatic set_node(int own, int count);
    cfg_wr_t w;
    drain();
    w.idx   = CfgOwnId;
    w.wdata = CfgDataW'(own);
    pending_writes.push_back(w);
    w.idx   = CfgNodeCount;
    w.wdata = CfgDataW'(count);
    pending_writes.push_back(w);
    do @(negedge clk); while (pending_writes.size() != 0 || cfg_if.valid);
    settings_used++;
    // Some phases run without any idling on either side
    no_gaps = ($urandom_range(0, 3) == 0);
  endtask

  // Mostly full rounds (want, a reply from most peers in random order with
  // stray requests mixed in, release), some lone items, some noise.
  // Noise that the node ignores does not count toward n.
  task automatic gen_random(int own, int count, int n);
    int made;
    int r;
    int j;
    int t;
    int p;
    int peers[$];
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        add_item(ModeWant, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        made++;
        peers.delete();
        for (p = 1; p <= count; p++) if (p != own) peers.push_back(p);
        for (j = peers.size() - 1; j > 0; j--) begin
          t = $urandom_range(0, j);
          p = peers[j];
          peers[j] = peers[t];
          peers[t] = p;
        end
        for (j = 0; j < peers.size(); j++) begin
          if ($urandom_range(0, 3) == 0) begin
            add_item(ModeMsg, MsgRequest, pick_peer(own, count));
            made++;
          end
          // Drop a reply now and then to break the round
          if ($urandom_range(0, 9) != 0) begin
            add_item(ModeMsg, MsgReply, 4'(peers[j]));
            made++;
          end
        end
        if ($urandom_range(0, 9) < 7) begin
          add_item(ModeRelease, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
          made++;
        end
      end else if (r < 85) begin
        case ($urandom_range(0, 3))
          0:       add_item(ModeWant, 1'($urandom_range(0, 1)),
                            4'($urandom_range(0, 15)));
          1:       add_item(ModeRelease, 1'($urandom_range(0, 1)),
                            4'($urandom_range(0, 15)));
          default: add_item(ModeMsg, 1'($urandom_range(0, 1)), pick_peer(own, count));
        endcase
        made++;
      end else if ($urandom_range(0, 1) == 0) begin
        add_item(ModeUnused, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      end else begin
        case ($urandom_range(0, 2))
          0:       p = 0;
          1:       p = own;
          default: p = (count < MaxNodes) ? $urandom_range(count + 1, MaxNodes) : 0;
        endcase
        add_item(ModeMsg, 1'($urandom_range(0, 1)), 4'(p));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Run sequence
  // ---------------------------------------------------------------------------
  initial begin
    int own;
    int count;
    // Hold every input at a known value from time zero
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    out_if.ready  = 1'b0;
    no_gaps       = 1'b0;
    idle_cycles   = 0;
    fail_count    = 0;
    items_seen    = 0;
    sends_checked = 0;
    grants_seen   = 0;
    forks_seen    = 0;
    requests_seen = 0;
    settings_used = 1;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings (id 1 of 2): ignored items first, then a full cycle
    add_item(ModeUnused, 1'b1, 4'd15);
    add_item(ModeUnused, 1'b0, 4'd0);
    add_item(ModeRelease, 1'b0, 4'd0);
    add_item(ModeMsg, MsgRequest, 4'd0);   // sender zero
    add_item(ModeMsg, MsgReply, 4'd1);     // sender is ourselves
    add_item(ModeMsg, MsgRequest, 4'd3);   // sender outside the peer range
    add_item(ModeMsg, MsgReply, 4'd15);
    add_item(ModeWant, 1'b0, 4'd0);        // no fork yet: ask for it
    add_item(ModeMsg, MsgRequest, 4'd2);   // request while waiting
    add_item(ModeMsg, MsgReply, 4'd2);     // clean fork arrives: grant
    add_item(ModeMsg, MsgRequest, 4'd2);   // request while not waiting
    add_item(ModeWant, 1'b1, 4'd15);       // clean fork held: grant at once
    add_item(ModeRelease, 1'b1, 4'd15);    // dirty everything
    add_item(ModeWant, 1'b0, 4'd2);        // dirty tokened fork goes out
    add_item(ModeMsg, MsgReply, 4'd2);

    // Highest id with the largest node: holds every fork from the start
    set_node(15, 15);
    add_item(ModeWant, 1'b0, 4'd0);
    add_item(ModeMsg, MsgRequest, 4'd14);
    add_item(ModeWant, 1'b1, 4'd7);
    add_item(ModeMsg, MsgRequest, 4'd3);
    add_item(ModeMsg, MsgReply, 4'd14);
    add_item(ModeMsg, MsgReply, 4'd3);
    add_item(ModeWant, 1'b0, 4'd1);

    // Random phases across the extremes and a few middle settings
    set_node(15, 15);
    gen_random(15, 15, 40);
    set_node(1, 15);
    gen_random(1, 15, 40);
    set_node(8, 15);
    gen_random(8, 15, 35);
    set_node(6, 3);                        // own id outside the node range
    gen_random(6, 3, 30);
    set_node(2, 2);
    gen_random(2, 2, 30);
    set_node(9, 12);
    gen_random(9, 12, 35);
    own   = $urandom_range(1, 15);
    count = $urandom_range(2, 15);
    set_node(own, count);
    gen_random(own, count, 30);
    set_node(1, 2);
    gen_random(1, 2, 30);

    drain();
    $display("Covered %0d items and %0d results over %0d id and size settings",
             items_seen, sends_checked, settings_used);
    $display("Saw %0d grants, %0d forks handed over, %0d request tokens sent",
             grants_seen, forks_seen, requests_seen);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== fork_token_mutex_node_core.f =====
sv/ftm_pkg.sv
sv/ftm_if.sv
sv/fork_token_mutex_node_core.sv
sim/testbench.sv
